[hw/rtl/noc_permutation_destination_defines.svh]
// ----------------------------------------------------------------------------
// noc_permutation_destination_defines
// Assertion macros shared by the destination generator RTL.
// ----------------------------------------------------------------------------
`ifndef NOC_PERMUTATION_DESTINATION_DEFINES_SVH
`define NOC_PERMUTATION_DESTINATION_DEFINES_SVH

// same-cycle implication, disabled in reset
`define NPD_ASSERT_IMP(lbl, a_clk, a_rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge a_clk) disable iff (!a_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define NPD_ASSERT_NXT(lbl, a_clk, a_rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge a_clk) disable iff (!a_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/nprm_pkg.sv]
// ----------------------------------------------------------------------------
// nprm_pkg
// Types and constants of the permutation destination generator.
// ----------------------------------------------------------------------------
`default_nettype none

package nprm_pkg;

    localparam int NODE_W  = 16;
    localparam int RADIX_W = 9;
    localparam int RECIP_W = 32;

    localparam logic [2:0] PAT_BITCOMP   = 3'd0;
    localparam logic [2:0] PAT_TRANSPOSE = 3'd1;
    localparam logic [2:0] PAT_BITREV    = 3'd2;
    localparam logic [2:0] PAT_SHUFFLE   = 3'd3;
    localparam logic [2:0] PAT_TORNADO   = 3'd4;
    localparam logic [2:0] PAT_NEIGHBOR  = 3'd5;

    localparam logic [1:0] REG_PATTERN   = 2'd0;
    localparam logic [1:0] REG_NODE_BITS = 2'd1;
    localparam logic [1:0] REG_RADIX     = 2'd2;
    localparam logic [1:0] REG_DIMS      = 2'd3;

    typedef enum logic [1:0] {
        ST_DIV,
        ST_SPAN,
        ST_DONE
    } setup_state_t;

    typedef struct packed {
        logic [NODE_W-1:0] q;
        logic [NODE_W-1:0] acc;
        logic [NODE_W-1:0] bit_res;
        logic              err;
        logic              digit;
    } item_t;

    typedef struct packed {
        logic [RADIX_W-1:0] radix;
        logic [RADIX_W-1:0] add;
        logic [RECIP_W-1:0] recip;
    } digit_cfg_t;

endpackage

`default_nettype wire

[hw/rtl/nprm_setup.sv]
// ----------------------------------------------------------------------------
// nprm_setup
// Derives reciprocal of the radix, digit place values and the range check
// after reset and after every configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

module nprm_setup #(
    parameter int ADDR_BITS = 16,
    parameter int MAX_DIMS  = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          restart,
    input  logic [nprm_pkg::RADIX_W-1:0]  radix,
    input  logic [3:0]                    dims,
    output logic                          busy,
    output logic [nprm_pkg::RECIP_W-1:0]  recip,
    output logic [nprm_pkg::NODE_W-1:0]   span [MAX_DIMS],
    output logic                          digit_bad
);
    import nprm_pkg::*;

    localparam int DIV_STEPS = RECIP_W + 1;
    localparam int CW        = $clog2(DIV_STEPS + MAX_DIMS);
    localparam int SW        = ADDR_BITS + 1;
    localparam int PW        = SW + RADIX_W;
    localparam logic [PW-1:0] LIMIT = PW'(1) << ADDR_BITS;

    setup_state_t state_reg, state_next;
    logic [CW-1:0]        cnt_reg;
    logic [RADIX_W-1:0]   rem_reg;
    logic [RECIP_W:0]     quo_reg;
    logic [SW-1:0]        span_cur_reg;
    logic                 over_reg;
    logic                 digit_bad_reg;
    logic [NODE_W-1:0]    span_reg [MAX_DIMS];

    logic [RADIX_W:0]     trial;
    logic                 qbit;
    logic [RADIX_W:0]     trial_sub;
    logic [PW-1:0]        prod;
    logic                 over_new;
    logic                 div_last;
    logic                 span_last;

    always_comb
    begin
        trial     = {rem_reg, (cnt_reg == '0)};
        qbit      = (trial >= {1'b0, radix});
        trial_sub = trial - {1'b0, radix};
        prod      = PW'(span_cur_reg) * PW'(radix);
        over_new  = over_reg || (prod > LIMIT);
        div_last  = (cnt_reg == CW'(DIV_STEPS - 1));
        span_last = (cnt_reg == CW'(MAX_DIMS - 1));
    end

    always_comb
    begin
        state_next = state_reg;
        if (restart)
        begin
            state_next = ST_DIV;
        end
        else
        begin
            case (state_reg)
                ST_DIV:
                begin
                    if (div_last)
                    begin
                        state_next = ST_SPAN;
                    end
                end
                ST_SPAN:
                begin
                    if (span_last)
                    begin
                        state_next = ST_DONE;
                    end
                end
                ST_DONE: state_next = ST_DONE;
                default: state_next = ST_DIV;
            endcase
        end
    end

    always_comb
    begin
        busy = (state_reg != ST_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_DIV;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            span_cur_reg  <= SW'(1);
            over_reg      <= 1'b0;
            digit_bad_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (restart)
            begin
                cnt_reg <= '0;
                rem_reg <= '0;
            end
            else
            begin
                case (state_reg)
                    ST_DIV:
                    begin
                        rem_reg <= qbit ? trial_sub[RADIX_W-1:0] : trial[RADIX_W-1:0];
                        if (div_last)
                        begin
                            cnt_reg      <= '0;
                            span_cur_reg <= SW'(1);
                            over_reg     <= 1'b0;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + CW'(1);
                        end
                    end
                    ST_SPAN:
                    begin
                        span_cur_reg <= prod[SW-1:0];
                        over_reg     <= over_new;
                        if (CW'(dims) == cnt_reg + CW'(1))
                        begin
                            digit_bad_reg <= over_new;
                        end
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                    default:
                    begin
                        cnt_reg <= cnt_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DIV)
        begin
            quo_reg <= {quo_reg[RECIP_W-1:0], qbit};
        end
        for (int k = 0; k < MAX_DIMS; k++)
        begin
            if ((state_reg == ST_SPAN) && (cnt_reg == CW'(k)))
            begin
                span_reg[k] <= span_cur_reg[NODE_W-1:0];
            end
        end
    end

    assign recip     = quo_reg[RECIP_W-1:0];
    assign span      = span_reg;
    assign digit_bad = digit_bad_reg;

endmodule

`default_nettype wire

[hw/rtl/nprm_digit.sv]
// ----------------------------------------------------------------------------
// nprm_digit
// One digit step: split off the low base-radix digit, shift it and add it
// back at its place value. Three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module nprm_digit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  nprm_pkg::item_t               in_item,
    input  nprm_pkg::digit_cfg_t          cfg,
    input  logic [nprm_pkg::NODE_W-1:0]   span,
    input  logic                          active,
    output logic                          out_valid,
    output nprm_pkg::item_t               out_item
);
    import nprm_pkg::*;

    localparam int PA_W = NODE_W + RECIP_W;
    localparam int PB_W = NODE_W + RADIX_W;

    logic              a_valid_reg, b_valid_reg, c_valid_reg;
    item_t             a_item_reg, b_item_reg, c_item_reg;
    logic [NODE_W-1:0] a_qe_reg;
    logic [RADIX_W-1:0] b_r_reg;

    logic [PA_W-1:0]    prod_a;
    logic [PB_W-1:0]    prod_b;
    logic [PB_W-1:0]    diff;
    logic [RADIX_W+1:0] r_raw;
    logic               corr;
    logic [RADIX_W+1:0] r_fix;
    item_t              b_item_next;
    logic [RADIX_W:0]   t;
    logic [RADIX_W:0]   nd;
    logic [PB_W-1:0]    term;
    item_t              c_item_next;

    always_comb
    begin
        prod_a = PA_W'(in_item.q) * PA_W'(cfg.recip);

        prod_b = PB_W'(a_qe_reg) * PB_W'(cfg.radix);
        diff   = PB_W'(a_item_reg.q) - prod_b;
        r_raw  = diff[RADIX_W+1:0];
        corr   = (r_raw >= (RADIX_W+2)'(cfg.radix));
        r_fix  = corr ? (r_raw - (RADIX_W+2)'(cfg.radix)) : r_raw;
        b_item_next   = a_item_reg;
        b_item_next.q = a_qe_reg + NODE_W'(corr);

        t    = (RADIX_W+1)'(b_r_reg) + (RADIX_W+1)'(cfg.add);
        nd   = (t >= (RADIX_W+1)'(cfg.radix)) ? (t - (RADIX_W+1)'(cfg.radix)) : t;
        term = PB_W'(span) * PB_W'(nd[RADIX_W-1:0]);
        c_item_next = b_item_reg;
        if (active)
        begin
            c_item_next.acc = b_item_reg.acc + term[NODE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_item_reg <= in_item;
        a_qe_reg   <= prod_a[PA_W-1:RECIP_W];
        b_item_reg <= b_item_next;
        b_r_reg    <= r_fix[RADIX_W-1:0];
        c_item_reg <= c_item_next;
    end

    assign out_valid = c_valid_reg;
    assign out_item  = c_item_reg;

endmodule

`default_nettype wire

[hw/rtl/noc_permutation_destination.sv]
// ----------------------------------------------------------------------------
// noc_permutation_destination
// Synthetic traffic destination generator: source node in, destination out.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with source_node while busy is low; the item is taken at that
//   edge. One result per item appears on dest_node and error for exactly one
//   cycle with done high, after the entry, digit-chain and output registers.
//   An item can be taken every cycle while busy is low; results leave in order,
//   one per cycle. The digit chain has three stages per digit (reciprocal
//   multiply, remainder fix-up, place-value accumulate).
//   Registers are written over the APB port at byte offsets 0, 4, 8, 12
//   (pattern, node_bits, radix, dims); write only with no item in flight.
//   After reset and after every register write busy stays high while the
//   radix reciprocal (one quotient bit per cycle) and then the digit place
//   values (one per cycle) are rebuilt.
//   The receiver cannot stall: done is a one-cycle strobe.
//   error is high with dest_node zero when the setup is invalid for the
//   selected pattern.
// ----------------------------------------------------------------------------
`default_nettype none
`include "noc_permutation_destination_defines.svh"

module noc_permutation_destination #(
    parameter int ADDR_BITS = 16,
    parameter int MAX_DIMS  = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [3:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         start,
    output logic                         busy,
    input  logic [nprm_pkg::NODE_W-1:0]  source_node,
    output logic                         done,
    output logic [nprm_pkg::NODE_W-1:0]  dest_node,
    output logic                         error
);
    import nprm_pkg::*;

    logic [2:0]          pattern_reg;
    logic [4:0]          node_bits_reg;
    logic [RADIX_W-1:0]  radix_reg;
    logic [3:0]          dims_reg;
    logic                cfg_wr;

    logic                setup_busy;
    logic [RECIP_W-1:0]  recip;
    logic [NODE_W-1:0]   span [MAX_DIMS];
    logic                digit_bad;
    digit_cfg_t          dcfg;

    logic [31:0]         s32, mask, mh, d_comp, d_tr, d_rev, rev, d_shuf, bit_d;
    logic [32:0]         m33;
    logic [3:0]          h;
    logic [5:0]          rsh;
    logic                bit_ok, bit_err, dig_err, is_bit, is_digit;
    item_t               entry_item;

    logic                s0_valid_reg;
    item_t               s0_item_reg;
    logic                v_chain [MAX_DIMS+1];
    item_t               i_chain [MAX_DIMS+1];

    logic                done_reg;
    logic [NODE_W-1:0]   dest_reg;
    logic                err_reg;
    item_t               last_item;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg   <= PAT_BITCOMP;
            node_bits_reg <= 5'd6;
            radix_reg     <= 9'd8;
            dims_reg      <= 4'd2;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_PATTERN:   pattern_reg   <= pwdata[2:0];
                REG_NODE_BITS: node_bits_reg <= pwdata[4:0];
                REG_RADIX:     radix_reg     <= pwdata[RADIX_W-1:0];
                REG_DIMS:      dims_reg      <= pwdata[3:0];
                default:       pattern_reg   <= pattern_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_PATTERN:   prdata = 32'(pattern_reg);
            REG_NODE_BITS: prdata = 32'(node_bits_reg);
            REG_RADIX:     prdata = 32'(radix_reg);
            REG_DIMS:      prdata = 32'(dims_reg);
            default:       prdata = '0;
        endcase
    end

    nprm_setup #(
        .ADDR_BITS (ADDR_BITS),
        .MAX_DIMS  (MAX_DIMS)
    ) u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (cfg_wr),
        .radix     (radix_reg),
        .dims      (dims_reg),
        .busy      (setup_busy),
        .recip     (recip),
        .span      (span),
        .digit_bad (digit_bad)
    );

    assign busy = setup_busy;

    always_comb
    begin
        dcfg.radix = radix_reg;
        dcfg.add   = (pattern_reg == PAT_TORNADO) ? ((radix_reg >> 1) - RADIX_W'(1))
                                                  : RADIX_W'(1);
        dcfg.recip = recip;
    end

    always_comb
    begin
        s32  = 32'(source_node);
        m33  = (33'd1 << node_bits_reg) - 33'd1;
        mask = m33[31:0];
        s32  = s32 & mask;
        h    = node_bits_reg[4:1];
        mh   = (32'd1 << h) - 32'd1;

        d_comp = ~s32 & mask;
        d_tr   = ((s32 >> h) & mh) | ((s32 << h) & (mh << h));
        for (int b = 0; b < 32; b++)
        begin
            rev[b] = s32[31-b];
        end
        rsh    = 6'd32 - {1'b0, node_bits_reg};
        d_rev  = rev >> rsh;
        d_shuf = ((s32 << 1) & mask) | ((s32 >> (node_bits_reg - 5'd1)) & 32'd1);

        case (pattern_reg)
            PAT_BITCOMP:   bit_d = d_comp;
            PAT_TRANSPOSE: bit_d = d_tr;
            PAT_BITREV:    bit_d = d_rev;
            default:       bit_d = d_shuf;
        endcase

        bit_ok  = (node_bits_reg != 5'd0) && ({1'b0, node_bits_reg} <= 6'(ADDR_BITS));
        bit_err = !bit_ok || ((pattern_reg == PAT_TRANSPOSE) && node_bits_reg[0]);
        dig_err = (radix_reg < 9'd2) || (dims_reg == 4'd0)
                  || ({1'b0, dims_reg} > 5'(MAX_DIMS)) || digit_bad;
        is_bit   = (pattern_reg == PAT_BITCOMP) || (pattern_reg == PAT_TRANSPOSE)
                   || (pattern_reg == PAT_BITREV) || (pattern_reg == PAT_SHUFFLE);
        is_digit = (pattern_reg == PAT_TORNADO) || (pattern_reg == PAT_NEIGHBOR);

        entry_item.q       = source_node;
        entry_item.acc     = '0;
        entry_item.bit_res = bit_d[NODE_W-1:0];
        entry_item.digit   = is_digit;
        entry_item.err     = is_bit ? bit_err : (is_digit ? dig_err : 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_item_reg <= entry_item;
    end

    assign v_chain[0] = s0_valid_reg;
    assign i_chain[0] = s0_item_reg;

    for (genvar n = 0; n < MAX_DIMS; n++)
    begin : g_digit
        nprm_digit u_digit (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v_chain[n]),
            .in_item   (i_chain[n]),
            .cfg       (dcfg),
            .span      (span[n]),
            .active    (5'(n) < {1'b0, dims_reg}),
            .out_valid (v_chain[n+1]),
            .out_item  (i_chain[n+1])
        );
    end

    assign last_item = i_chain[MAX_DIMS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= v_chain[MAX_DIMS];
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg  <= last_item.err;
        dest_reg <= last_item.err ? '0
                    : (last_item.digit ? last_item.acc : last_item.bit_res);
    end

    assign done      = done_reg;
    assign dest_node = dest_reg;
    assign error     = err_reg;

    `NPD_ASSERT_IMP(a_err_dest_zero, clk, rst_n, done && error, dest_node == '0, "error with nonzero dest")
    `NPD_ASSERT_NXT(a_busy_no_entry, clk, rst_n, busy, !s0_valid_reg, "item entered while busy")
    `NPD_ASSERT_NXT(a_cfg_sets_busy, clk, rst_n, cfg_wr, busy, "setup not restarted on write")

endmodule

`default_nettype wire

[tb/noc_permutation_destination_checker.sv]
// ----------------------------------------------------------------------------
// noc_permutation_destination_checker
// Watches the config port, the item input and the result strobe; predicts
// each destination from the shadow registers and compares in order.
// ----------------------------------------------------------------------------
`default_nettype none

module noc_permutation_destination_checker (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    input  wire         pready,
    input  wire         start,
    input  wire         busy,
    input  wire  [15:0] source_node,
    input  wire         done,
    input  wire  [15:0] dest_node,
    input  wire         error,
    output int          fail_count,
    output int          pending
);
    import nprm_pkg::*;

    logic [2:0] pattern_q;
    logic [4:0] node_bits_q;
    logic [8:0] radix_q;
    logic [3:0] dims_q;
    logic [16:0] dest_q[$];

    // returns {error, dest}
    function automatic logic [16:0] map_dest(logic [15:0] src);
        int unsigned lg;
        int unsigned h;
        longint unsigned m;
        longint unsigned s;
        longint unsigned d;
        longint unsigned span;
        longint unsigned add;
        longint unsigned dig;
        lg = node_bits_q;
        d = 0;
        if (pattern_q <= PAT_SHUFFLE) begin
            if (lg == 0 || lg > 16)
                return 17'h10000;
            m = (64'd1 << lg) - 1;
            s = src & m;
            if (pattern_q == PAT_BITCOMP)
                d = ~s & m;
            else if (pattern_q == PAT_TRANSPOSE) begin
                if (lg[0])
                    return 17'h10000;
                h = lg / 2;
                d = ((s >> h) & ((64'd1 << h) - 1)) | ((s << h) & (((64'd1 << h) - 1) << h));
            end
            else if (pattern_q == PAT_BITREV) begin
                for (int b = 0; b < lg; b++)
                    d |= ((s >> b) & 1) << (lg - b - 1);
            end
            else
                d = ((s << 1) & m) | ((s >> (lg - 1)) & 1);
        end
        else if (pattern_q <= PAT_NEIGHBOR) begin
            if (radix_q < 2 || dims_q == 0 || dims_q > 8)
                return 17'h10000;
            span = 1;
            for (int n = 0; n < dims_q; n++) begin
                span *= radix_q;
                if (span > 65536)
                    return 17'h10000;
            end
            add = (pattern_q == PAT_TORNADO) ? (radix_q / 2 - 1) : 1;
            span = 1;
            for (int n = 0; n < dims_q; n++) begin
                dig = (src / span) % radix_q;
                d += span * ((dig + add) % radix_q);
                span *= radix_q;
            end
        end
        else
            return 17'h10000;
        return {1'b0, d[15:0]};
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [16:0] exp_v;
        if (!rst_n) begin
            pattern_q   <= PAT_BITCOMP;
            node_bits_q <= 5'd6;
            radix_q     <= 9'd8;
            dims_q      <= 4'd2;
            dest_q.delete();
            fail_count  <= 0;
            pending     <= 0;
        end
        else begin
            if (done) begin
                if (dest_q.size() == 0)
                    report_mismatch("result with no item waiting");
                else begin
                    exp_v = dest_q.pop_front();
                    if (dest_node !== exp_v[15:0] || error !== exp_v[16])
                        report_mismatch($sformatf("dest %h err %b, want dest %h err %b",
                            dest_node, error, exp_v[15:0], exp_v[16]));
                end
            end
            if (start && !busy)
                dest_q.insert(dest_q.size(), map_dest(source_node));
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_PATTERN:   pattern_q   <= pwdata[2:0];
                    REG_NODE_BITS: node_bits_q <= pwdata[4:0];
                    REG_RADIX:     radix_q     <= pwdata[8:0];
                    default:       dims_q      <= pwdata[3:0];
                endcase
            end
            pending <= dest_q.size();
        end
    end
endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Drives source nodes through the destination generator under a series of
// pattern, node-count, radix and dimension settings, with random gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import nprm_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        start = 1'b0;
    logic [15:0] source_node = '0;
    wire  [31:0] prdata;
    wire         pready;
    wire         busy;
    wire         done;
    wire  [15:0] dest_node;
    wire         error;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    bit          calm = 1'b0;

    always #2 clk = ~clk;

    noc_permutation_destination i_dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy), .source_node(source_node), .done(done),
        .dest_node(dest_node), .error(error)
    );

    noc_permutation_destination_checker i_checker (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .pready(pready), .start(start), .busy(busy),
        .source_node(source_node), .done(done), .dest_node(dest_node),
        .error(error), .fail_count(fail_count), .pending(pending)
    );

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        while (busy)
            @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_item(logic [15:0] src);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        source_node <= src;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_all(int pat, int nb, int rdx, int dm);
        write_reg(REG_PATTERN, pat);
        write_reg(REG_NODE_BITS, nb);
        write_reg(REG_RADIX, rdx);
        write_reg(REG_DIMS, dm);
    endtask

    task automatic random_src(int n);
        for (int i = 0; i < n; i++)
            send_item($urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 255))
                                                 : 16'($urandom));
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        // directed: reset setting, extremes and each pattern
        send_item(16'h0000);
        send_item(16'hFFFF);
        send_item(16'h002A);
        drain();
        set_all(PAT_TRANSPOSE, 16, 256, 2);
        send_item(16'h1234);
        send_item(16'hFFFF);
        drain();
        write_reg(REG_NODE_BITS, 7);
        send_item(16'h0055);
        drain();
        set_all(PAT_BITREV, 1, 2, 1);
        send_item(16'hFFFF);
        send_item(16'h0000);
        drain();
        set_all(PAT_SHUFFLE, 0, 2, 1);
        send_item(16'h8001);
        drain();
        write_reg(REG_NODE_BITS, 17);
        send_item(16'h8001);
        drain();
        set_all(PAT_TORNADO, 31, 256, 2);
        send_item(16'hFFFF);
        send_item(16'h0000);
        drain();
        set_all(PAT_NEIGHBOR, 16, 2, 8);
        send_item(16'hFFFF);
        drain();
        set_all(PAT_NEIGHBOR, 16, 511, 1);
        send_item(16'hABCD);
        drain();
        set_all(PAT_TORNADO, 16, 1, 2);
        send_item(16'h0101);
        drain();
        set_all(PAT_TORNADO, 16, 3, 15);
        send_item(16'h0101);
        drain();
        write_reg(REG_DIMS, 0);
        send_item(16'h0101);
        drain();
        set_all(6, 16, 8, 2);
        send_item(16'h0101);
        drain();
        write_reg(REG_PATTERN, 7);
        send_item(16'h0101);
        drain();
        // random phases, mostly valid settings
        for (int ph = 0; ph < 32; ph++) begin
            if ($urandom_range(0, 5) == 0)
                set_all($urandom_range(0, 7), $urandom_range(0, 31),
                        $urandom_range(0, 511), $urandom_range(0, 15));
            else
                set_all($urandom_range(0, 5), $urandom_range(1, 16),
                        $urandom_range(2, 256), $urandom_range(1, 8));
            if (ph == 28)
                calm = 1'b1;
            random_src(50);
            drain();
        end
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

`default_nettype wire
